@@ design/rfp_pkg.sv @@
// shared types and constants for the response frame parser
package rfp_pkg;

	localparam int QueueDepthDefault = 4;

	localparam logic [7:0] PREAMBLE_1 = 8'hAA;
	localparam logic [7:0] PREAMBLE_2 = 8'hBB;
	localparam logic [7:0] STUFF_BYTE = 8'h00;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_GOOD = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	// one received request after classification
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_timeout;
		logic       is_pre1;
		logic       is_pre2;
		logic       is_stuff;
	} rfp_item_t;

endpackage

@@ design/response_frame_parser.sv @@
// top level of the response frame parser
// Byte-serial deframer for reader response frames (AA BB, 16-bit little-endian
// length, payload, xor checksum). One request is taken per clock when both
// sides keep up. An accepted request goes first into the classifier
// register and then into the queue; the state machine loads the result
// register from the queue head at the edge that pops the queue.
// The rate of one request per cycle is set by the frame state machine, which
// retires one queued request per cycle whenever the result register is free
// or being taken. The queue of QUEUE_DEPTH entries lets the input side keep
// accepting while the output side stalls. Payload bytes come out as kind 0
// with their index; the checksum byte ends the frame as kind 1 (good) or
// kind 2 (bad) with the payload count. A stuffing zero after an AA inside the
// payload is dropped. Timeout requests and preamble or length bytes give no
// result.
module response_frame_parser
	import rfp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        is_timeout,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index
);

	// classified request into the queue
	logic      push_valid;
	logic      push_ready;
	rfp_item_t push_item;

	// queue head toward the state machine
	logic      pop_valid;
	logic      pop_ready;
	rfp_item_t pop_item;

	rfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.is_timeout (is_timeout),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decouples classification from frame handling
	rfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// frame state, length, count and checksum live here
	rfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.byte_index (byte_index)
	);

endmodule

@@ design/rfp_front.sv @@
// front stage: takes requests and tags them with byte classes
module rfp_front
	import rfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       is_timeout,
	output logic       push_valid,
	input  logic       push_ready,
	output rfp_item_t  push_item
);

	logic      vld_s1;
	rfp_item_t item_s1;

	assign in_ready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rx_byte    <= rx_byte;
			item_s1.is_timeout <= is_timeout;
			item_s1.is_pre1    <= (rx_byte == PREAMBLE_1);
			item_s1.is_pre2    <= (rx_byte == PREAMBLE_2);
			item_s1.is_stuff   <= (rx_byte == STUFF_BYTE);
		end
	end

endmodule

@@ design/rfp_queue.sv @@
// small fifo between the classifier and the frame state machine
module rfp_queue
	import rfp_pkg::*;
#(
	parameter int DEPTH = QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  rfp_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output rfp_item_t pop_item
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	rfp_item_t       mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntFull);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ design/rfp_back.sv @@
// back stage: frame state machine, checksum and result register
module rfp_back
	import rfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  rfp_item_t   pop_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index
);

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_PRE2    = 7'b0000010,
		PH_LEN1    = 7'b0000100,
		PH_LEN2    = 7'b0001000,
		PH_PAYLOAD = 7'b0010000,
		PH_CSUM    = 7'b0100000,
		PH_ERROR   = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  xor_q, xor_d;
	logic        prev_aa_q, prev_aa_d;
	logic        out_vld_q;
	logic [1:0]  kind_q;
	logic [7:0]  data_q;
	logic [15:0] index_q;

	logic        emit;
	logic [1:0]  emit_kind;
	logic [16:0] cnt_next;
	logic [16:0] len_m1;
	logic        last_payload;
	logic        take;

	assign out_valid  = out_vld_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign byte_index = index_q;

	assign pop_ready = !out_vld_q || out_ready;
	assign take      = pop_valid && pop_ready;

	assign cnt_next     = {1'b0, cnt_q} + 17'd1;
	assign len_m1       = {1'b0, len_q} - 17'd1;
	assign last_payload = (len_q < 16'd2) || (cnt_next >= len_m1);

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		xor_d     = xor_q;
		prev_aa_d = prev_aa_q;
		emit      = 1'b0;
		emit_kind = KIND_DATA;
		if (pop_item.is_timeout) begin
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_PRE2: begin
					phase_d = pop_item.is_pre2 ? PH_LEN1 : PH_ERROR;
				end
				PH_LEN1: begin
					len_d   = {8'h00, pop_item.rx_byte};
					phase_d = PH_LEN2;
				end
				PH_LEN2: begin
					len_d     = {pop_item.rx_byte, len_q[7:0]};
					cnt_d     = '0;
					xor_d     = '0;
					prev_aa_d = 1'b0;
					phase_d   = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (prev_aa_q && pop_item.is_stuff) begin
						// stuffing zero after an aa byte is dropped
						prev_aa_d = 1'b0;
					end else begin
						emit      = 1'b1;
						xor_d     = xor_q ^ pop_item.rx_byte;
						prev_aa_d = pop_item.is_pre1;
						cnt_d     = cnt_next[15:0];
						if (last_payload) begin
							phase_d = PH_CSUM;
						end
					end
				end
				PH_CSUM: begin
					emit      = 1'b1;
					emit_kind = (xor_q == pop_item.rx_byte) ? KIND_GOOD : KIND_BAD;
					phase_d   = PH_IDLE;
				end
				PH_IDLE, PH_ERROR: begin
					phase_d = pop_item.is_pre1 ? PH_PRE2 : PH_ERROR;
				end
				default: begin
					phase_d = pop_item.is_pre1 ? PH_PRE2 : PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			len_q     <= '0;
			cnt_q     <= '0;
			xor_q     <= '0;
			prev_aa_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q   <= phase_d;
				len_q     <= len_d;
				cnt_q     <= cnt_d;
				xor_q     <= xor_d;
				prev_aa_q <= prev_aa_d;
			end
			if (pop_ready) begin
				out_vld_q <= take && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q  <= emit_kind;
			data_q  <= pop_item.rx_byte;
			index_q <= cnt_q;
		end
	end

endmodule

@@ tb/sv/response_frame_parser_tb.sv @@
// self-checking testbench for the response frame parser
module response_frame_parser_tb;
	import rfp_pkg::*;

	// run limits
	localparam int RANDOM_REQUESTS = 1250;
	localparam int CALM_FIRST      = 400;   // no idling on either side in this window
	localparam int CALM_LAST       = 650;
	localparam int HOLD_OFF_AT     = 900;   // receiver holds off here
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PAUSE_AT        = 1100;  // sender pauses until everything is out
	localparam int IDLE_PERCENT    = 20;
	localparam int WATCHDOG_LIMIT  = 4000;  // well above the hold-off and any drain
	localparam int DRAIN_CYCLES    = 16;    // margin after the last expected result
	localparam int REPORT_LIMIT    = 10;

	// how a table row is checked
	typedef enum logic [1:0] {
		ROW_PREDICT,  // expected result comes from the predictor
		ROW_SILENT,   // no result expected
		ROW_RESULT    // result typed into the row
	} row_check_t;

	// one result of the parser
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] idx;
	} parse_result_t;

	// one row of the directed table
	typedef struct packed {
		logic [7:0]    rx;
		logic          tmo;
		row_check_t    chk;
		parse_result_t res;
	} directed_row_t;

	// predictor phases
	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC_BB,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_PAYLOAD,
		ST_CHECKSUM,
		ST_LOST
	} parse_state_t;

	localparam int DIRECTED_COUNT = 25;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// bad first preamble byte right after reset, no result
		'{8'h55,      1'b0, ROW_SILENT,  '{KIND_DATA, 8'h00, 16'd0}},
		// lost state stays lost on a non-AA byte
		'{STUFF_BYTE, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		// AA resynchronizes
		'{PREAMBLE_1, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		// wrong second preamble byte
		'{STUFF_BYTE, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		// zero-length frame still takes one payload byte
		'{PREAMBLE_1, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{PREAMBLE_2, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{8'h00,      1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{8'h00,      1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{8'hFF,      1'b0, ROW_RESULT,  '{KIND_DATA, 8'hFF, 16'd0}},
		'{8'hFF,      1'b0, ROW_RESULT,  '{KIND_GOOD, 8'hFF, 16'd1}},
		// length 5: four kept payload bytes, with stuffing
		'{PREAMBLE_1, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{PREAMBLE_2, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{8'h05,      1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{8'h00,      1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{PREAMBLE_1, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		// stuffing zero dropped
		'{STUFF_BYTE, 1'b0, ROW_SILENT,  '{KIND_DATA, 8'h00, 16'd0}},
		// a second zero is data
		'{STUFF_BYTE, 1'b0, ROW_RESULT,  '{KIND_DATA, 8'h00, 16'd1}},
		'{PREAMBLE_1, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{STUFF_BYTE, 1'b0, ROW_SILENT,  '{KIND_DATA, 8'h00, 16'd0}},
		'{8'h7E,      1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		// checksum should be 7E, so this ends the frame as bad
		'{8'h00,      1'b0, ROW_RESULT,  '{KIND_BAD,  8'h00, 16'd4}},
		// timeout in the middle of the header
		'{PREAMBLE_1, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{PREAMBLE_2, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}},
		'{8'hFF,      1'b1, ROW_SILENT,  '{KIND_DATA, 8'h00, 16'd0}},
		// back in hunt, BB is a bad first byte
		'{PREAMBLE_2, 1'b0, ROW_PREDICT, '{KIND_DATA, 8'h00, 16'd0}}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        is_timeout;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;

	// typed expectation travelling with the request on the input
	row_check_t    req_check;
	parse_result_t req_result;

	// predictor state
	parse_state_t parse_state = ST_HUNT;
	logic [15:0]  hdr_length  = '0;
	logic [15:0]  kept_count  = '0;
	logic [7:0]   xor_sum     = '0;
	logic         last_was_aa = 1'b0;

	parse_result_t pending_results [$];
	int            mismatch_count = 0;
	int            requests_sent  = 0;
	int            stall_cycles   = 0;

	// shared between sender and receiver processes
	logic calm;
	int   hold_off_asks;

	response_frame_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.is_timeout (is_timeout),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.byte_index (byte_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the frame parser by one request, giving its result if any
	function automatic void parse_request(input logic [7:0] b, input logic tmo,
			output bit emits, output parse_result_t res);
		logic [16:0] next_count;
		emits = 1'b0;
		res   = '0;
		if (tmo) begin
			// timeout only resets the phase
			parse_state = ST_HUNT;
			return;
		end
		case (parse_state)
			ST_SYNC_BB: begin
				parse_state = (b == PREAMBLE_2) ? ST_LEN_LO : ST_LOST;
			end
			ST_LEN_LO: begin
				hdr_length  = {8'h00, b};
				parse_state = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				hdr_length[15:8] = b;
				kept_count       = '0;
				xor_sum          = '0;
				last_was_aa      = 1'b0;
				parse_state      = ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				if (last_was_aa && b == STUFF_BYTE) begin
					// stuffing zero: dropped, not counted, not summed
					last_was_aa = 1'b0;
				end else begin
					emits       = 1'b1;
					res         = '{KIND_DATA, b, kept_count};
					xor_sum     = xor_sum ^ b;
					last_was_aa = (b == PREAMBLE_1);
					next_count  = {1'b0, kept_count} + 17'd1;
					kept_count  = next_count[15:0];
					// short lengths still end after one byte
					if (hdr_length < 16'd2 || next_count >= {1'b0, hdr_length} - 17'd1)
						parse_state = ST_CHECKSUM;
				end
			end
			ST_CHECKSUM: begin
				emits       = 1'b1;
				res         = '{(xor_sum == b) ? KIND_GOOD : KIND_BAD, b, kept_count};
				parse_state = ST_HUNT;
			end
			default: begin
				// hunt and lost both wait for AA
				parse_state = (b == PREAMBLE_1) ? ST_SYNC_BB : ST_LOST;
			end
		endcase
	endfunction

	function automatic void report_mismatch(input string what, input parse_result_t want,
			input parse_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$write("mismatch (%s): expected kind %0d data %02h index %0d, ",
				what, want.kind, want.data, want.idx);
			$display("got kind %0d data %02h index %0d", got.kind, got.data, got.idx);
		end
	endfunction

	// scoreboard and watchdog: requests are predicted before results are popped,
	// so a request and a result at the same edge keep their order
	always @(posedge clk) begin : scoreboard
		bit            emits;
		parse_result_t res;
		parse_result_t got;
		parse_result_t want;
		bit            moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				moved = 1'b1;
				parse_request(rx_byte, is_timeout, emits, res);
				// typed rows override the predictor, which still tracks the state
				if (req_check == ROW_SILENT) begin
					emits = 1'b0;
				end else if (req_check == ROW_RESULT) begin
					emits = 1'b1;
					res   = req_result;
				end
				if (emits)
					pending_results.push_back(res);
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got   = '{kind, data_byte, byte_index};
				if (pending_results.size() == 0) begin
					report_mismatch("no result expected", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got.kind !== want.kind || got.data !== want.data || got.idx !== want.idx)
						report_mismatch("wrong field", want, got);
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: random stalls, a calm window and one long hold-off
	initial begin : receiver
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_asks != hold_seen) begin
				hold_seen = hold_off_asks;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// offer one request and wait for it to be taken
	task automatic send_request(input logic [7:0] b, input logic tmo,
			input row_check_t chk = ROW_PREDICT, input parse_result_t res = '0);
		bit quiet;
		quiet = (requests_sent >= CALM_FIRST && requests_sent < CALM_LAST);
		calm <= quiet;
		if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < IDLE_PERCENT);
		end
		in_valid   <= 1'b1;
		rx_byte    <= b;
		is_timeout <= tmo;
		req_check  <= chk;
		req_result <= res;
		do
			@(posedge clk);
		while (!in_ready);
		requests_sent++;
	endtask

	// drop valid and wait until every expected result is out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// random byte leaning on the values the parser treats specially
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0:       return PREAMBLE_1;
			1:       return STUFF_BYTE;
			default: return 8'($urandom);
		endcase
	endfunction

	// well-formed frame with random content, sometimes cut by a timeout
	task automatic send_frame();
		logic [15:0] frame_len;
		int          need;
		int          kept;
		int          sent;
		int          cut_at;
		logic [7:0]  acc;
		logic [7:0]  b;
		bit          aa;
		frame_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
		                                       : 16'($urandom_range(0, 8));
		need      = (frame_len < 16'd2) ? 1 : int'(frame_len) - 1;
		cut_at    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, need - 1) : -1;
		kept      = 0;
		sent      = 0;
		acc       = '0;
		aa        = 1'b0;
		send_request(PREAMBLE_1, 1'b0);
		send_request(PREAMBLE_2, 1'b0);
		send_request(frame_len[7:0], 1'b0);
		send_request(frame_len[15:8], 1'b0);
		while (kept < need) begin
			if (sent == cut_at) begin
				send_request(8'($urandom), 1'b1);
				return;
			end
			b = pick_byte();
			send_request(b, 1'b0);
			sent++;
			// mirror the stuffing rule so the frame ends where it should
			if (aa && b == STUFF_BYTE) begin
				aa = 1'b0;
			end else begin
				kept++;
				acc = acc ^ b;
				aa  = (b == PREAMBLE_1);
			end
		end
		// mostly a good checksum, sometimes a random one
		send_request(($urandom_range(0, 3) == 0) ? 8'($urandom) : acc, 1'b0);
	endtask

	// header with any length, a few bytes, then a timeout
	task automatic send_broken_frame();
		int n;
		n = $urandom_range(1, 6);
		send_request(PREAMBLE_1, 1'b0);
		send_request(PREAMBLE_2, 1'b0);
		send_request(8'($urandom), 1'b0);
		send_request(8'($urandom), 1'b0);
		repeat (n) send_request(pick_byte(), 1'b0);
		send_request(8'($urandom), 1'b1);
	endtask

	// line noise: random bytes, preamble bytes and timeouts
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				send_request(8'($urandom), 1'b1);
			else if ($urandom_range(0, 2) == 0)
				send_request($urandom_range(0, 1) ? PREAMBLE_1 : PREAMBLE_2, 1'b0);
			else
				send_request(8'($urandom), 1'b0);
		end
	endtask

	// sender: directed table, then random frames with the pressure events
	initial begin : sender
		bit hold_done;
		bit pause_done;
		int pick;
		hold_done     = 1'b0;
		pause_done    = 1'b0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		rx_byte       <= '0;
		is_timeout    <= 1'b0;
		req_check     <= ROW_PREDICT;
		req_result    <= '0;
		calm          <= 1'b0;
		hold_off_asks <= 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_request(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].tmo,
				DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].res);
		wait_for_results();

		// random part
		while (requests_sent < DIRECTED_COUNT + RANDOM_REQUESTS) begin
			if (!hold_done && requests_sent >= HOLD_OFF_AT) begin
				// receiver stops while requests keep coming, filling the queue
				hold_off_asks <= hold_off_asks + 1;
				hold_done = 1'b1;
			end
			if (!pause_done && requests_sent >= PAUSE_AT) begin
				wait_for_results();
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 72)
				send_frame();
			else if (pick < 84)
				send_broken_frame();
			else
				send_noise();
		end

		// drain and let the pipeline settle
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			if (pending_results.size() != 0)
				$display("%0d expected results never arrived", pending_results.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ response_frame_parser.f @@
design/rfp_pkg.sv
design/rfp_front.sv
design/rfp_queue.sv
design/rfp_back.sv
design/response_frame_parser.sv
tb/sv/response_frame_parser_tb.sv
